[rtl/dtmh_pkg.sv]
// Package: constants, types and codes for the deadline task heap.
`timescale 1ns / 1ps
package dtmh_pkg;
  localparam int unsigned Depth    = 256;
  localparam int unsigned TimeBits = 64;
  localparam int unsigned IdBits   = 16;
  localparam int unsigned AddrBits = $clog2(Depth);
  localparam int unsigned CntBits  = $clog2(Depth + 1);
  localparam int unsigned EntBits  = TimeBits + IdBits;

  localparam logic [1:0] FuncSched  = 2'd0;
  localparam logic [1:0] FuncPop    = 2'd1;
  localparam logic [1:0] FuncCancel = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotDue   = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_SRCH, S_SRCHW, S_LAST, S_UPR, S_UPC, S_DNR,
    S_DNL, S_DNC, S_FIN, S_OUT
  } state_e;
endpackage

[rtl/dtmh_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module dtmh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/deadline_task_min_heap.sv]
// Top level: deadline-ordered binary min-heap of tasks.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o) transfers one operation: func_i
//   selects schedule, pop-due or cancel; deadline_i, now_time_i, task_id_i
//   are its operands. Output channel (out_valid_o/out_ready_i) transfers
//   exactly one result per operation: status, removed task, head deadline,
//   head valid and entry count after the operation.
//   One operation at a time. Entries live in one RAM (deadline and id packed)
//   with a registered read, one access per cycle; the head deadline is
//   kept in a register. Schedule sifts the new entry up level by level and
//   pop sifts the moved last entry down; rejected operations go straight
//   to the output. Cancel scans entries one per cycle in address order
//   (all of them when the id is absent) and then sifts up or down as above.
//   Reset clears the count, the head register and control only; the RAM
//   needs no clearing since only slots below the count are ever used.
//   A result waits in the output register while the receiver stalls; the
//   next operation is accepted in the cycle after the result transfers.
module deadline_task_min_heap
  import dtmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] deadline_i,
  input  logic [63:0] now_time_i,
  input  logic [15:0] task_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_task_id_o,
  output logic [63:0] out_deadline_o,
  output logic        head_valid_o,
  output logic [63:0] head_deadline_o,
  output logic [8:0]  entry_count_o
);
  state_e state_q, state_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [AddrBits-1:0] pos_q, pos_d;      // current sift position
  logic [CntBits-1:0]  idx_q, idx_d;      // scan index
  logic [EntBits-1:0]  cur_q, cur_d;      // entry being moved
  logic [EntBits-1:0]  lch_q, lch_d;      // left child latched
  logic                lok_q, lok_d;
  logic [15:0]         id_q, id_d;
  logic [63:0]         head_q, head_d;
  logic [1:0]          st_q, st_d;
  logic [EntBits-1:0]  rem_q, rem_d;
  logic                canc_q, canc_d;    // cancel: try up first

  logic                we;
  logic [AddrBits-1:0] addr;
  logic [EntBits-1:0]  wdata, rdata;

  dtmh_ram #(.Width(EntBits), .Depth(Depth)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [TimeBits-1:0] rd_dl, cur_dl, lch_dl;
  logic [IdBits-1:0]   rd_id;
  logic [CntBits-1:0]  lidx, ridx;
  logic [AddrBits-1:0] parent;
  assign rd_dl  = rdata[EntBits-1:IdBits];
  assign rd_id  = rdata[IdBits-1:0];
  assign cur_dl = cur_q[EntBits-1:IdBits];
  assign lch_dl = lch_q[EntBits-1:IdBits];
  assign lidx   = {pos_q, 1'b1};
  assign ridx   = {pos_q, 1'b0} + CntBits'(2);
  assign parent = AddrBits'((pos_q - AddrBits'(1)) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; idx_q <= idx_d; cur_q <= cur_d; lch_q <= lch_d;
    lok_q <= lok_d; id_q <= id_d;
    st_q <= st_d; rem_q <= rem_d; canc_q <= canc_d;
  end

  // Next state and datapath.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; head_d = head_q;
    pos_d = pos_q; idx_d = idx_q; cur_d = cur_q; lch_d = lch_q; lok_d = lok_q;
    id_d = id_q; st_d = st_q; rem_d = rem_q;
    canc_d = canc_q;
    we = 1'b0; addr = pos_q; wdata = cur_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          id_d = task_id_i;
          st_d = StOk; rem_d = '0; canc_d = 1'b0; lok_d = 1'b0;
          cur_d = {deadline_i, task_id_i};
          case (func_i)
            FuncSched: begin
              if (cnt_q == CntBits'(Depth)) begin
                st_d = StFull; state_d = S_OUT;
              end else begin
                pos_d = AddrBits'(cnt_q);
                cnt_d = cnt_q + CntBits'(1);
                state_d = S_UPR;
              end
            end
            FuncPop: begin
              if (cnt_q == '0 || head_q > now_time_i) begin
                st_d = StNotDue; state_d = S_OUT;
              end else begin
                addr = '0; state_d = S_HEAD;
              end
            end
            FuncCancel: begin
              st_d = StNotFound; idx_d = '0;
              state_d = (cnt_q == '0) ? S_OUT : S_SRCH;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_HEAD: begin // read data is root; fetch last
        addr = '0; state_d = S_HEAD;
        rem_d = rdata; // root read issued in IDLE
        cnt_d = cnt_q - CntBits'(1);
        addr = AddrBits'(cnt_q - CntBits'(1));
        pos_d = '0;
        state_d = S_LAST;
      end
      S_SRCH: begin
        addr = AddrBits'(idx_q); state_d = S_SRCHW;
      end
      S_SRCHW: begin
        addr = AddrBits'(idx_q);
        if (rd_id == id_q) begin
          st_d = StOk; pos_d = AddrBits'(idx_q);
          cnt_d = cnt_q - CntBits'(1);
          addr = AddrBits'(cnt_q - CntBits'(1));
          canc_d = 1'b1;
          state_d = S_LAST;
        end else if (idx_q + CntBits'(1) == cnt_q) begin
          state_d = S_OUT;
        end else begin
          idx_d = idx_q + CntBits'(1);
          addr = AddrBits'(idx_q + CntBits'(1));
        end
      end
      S_LAST: begin // rdata = last entry; move it to pos
        cur_d = rdata;
        if (CntBits'(pos_q) >= cnt_q) begin
          state_d = S_FIN; // removed entry was last
        end else begin
          state_d = canc_q ? S_UPR : S_DNR;
        end
      end
      S_UPR: begin // write cur at pos; parent is read in UPC
        we = 1'b1; addr = pos_q;
        state_d = (pos_q == '0) ? (canc_q ? S_DNR : S_FIN) : S_UPC;
        if (pos_q != '0) begin
          lch_d[AddrBits-1:0] = pos_q;
        end
      end
      S_UPC: begin
        addr = parent; state_d = S_UPC;
        if (lok_q) begin
          lok_d = 1'b0;
          if (cur_dl < rd_dl) begin
            we = 1'b1; addr = pos_q; wdata = rdata;
            pos_d = parent; canc_d = 1'b0;
            state_d = S_UPR;
          end else begin
            state_d = canc_q ? S_DNR : S_FIN;
          end
        end else begin
          lok_d = 1'b1;
        end
      end
      S_DNR: begin // write cur at pos; left child is read in DNL
        canc_d = 1'b0;
        we = 1'b1; addr = pos_q; wdata = cur_q;
        if (lidx >= cnt_q) state_d = S_FIN;
        else state_d = S_DNL;
        lok_d = 1'b0;
      end
      S_DNL: begin
        addr = AddrBits'(lidx);
        if (lok_q) begin
          lch_d = rdata; lok_d = 1'b0;
          if (ridx < cnt_q) begin
            addr = AddrBits'(ridx); state_d = S_DNC;
          end else begin
            if (rd_dl < cur_dl) begin
              we = 1'b1; addr = pos_q; wdata = rdata;
              pos_d = AddrBits'(lidx); state_d = S_DNR;
            end else state_d = S_FIN;
          end
        end else lok_d = 1'b1;
      end
      S_DNC: begin // rdata = right child
        if (rd_dl < lch_dl && rd_dl < cur_dl) begin
          we = 1'b1; addr = pos_q; wdata = rdata;
          pos_d = AddrBits'(ridx); state_d = S_DNR;
        end else if (lch_dl < cur_dl) begin
          we = 1'b1; addr = pos_q; wdata = lch_q;
          pos_d = AddrBits'(lidx); state_d = S_DNR;
        end else state_d = S_FIN;
      end
      S_FIN: begin // refresh head register from root
        addr = '0;
        if (lok_q) begin
          lok_d = 1'b0;
          head_d = (cnt_q == '0) ? '0 : 64'(rd_dl);
          state_d = S_OUT;
        end else lok_d = 1'b1;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    in_ready_o      = (state_q == S_IDLE);
    out_valid_o     = (state_q == S_OUT);
    status_o        = st_q;
    out_task_id_o   = 16'(rem_q[IdBits-1:0]);
    out_deadline_o  = 64'(rem_q[EntBits-1:IdBits]);
    head_valid_o    = (cnt_q != '0);
    head_deadline_o = (cnt_q != '0) ? head_q : '0;
    entry_count_o   = 9'(cnt_q);
  end
endmodule

[tb/tb_top.sv]
// Testbench for the deadline task heap: directed and random traffic checked against a behavioral heap.
`timescale 1ns / 1ps

module tb_top
  import dtmh_pkg::*;
();

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] task_id;
    logic [63:0] deadline;
    logic        head_valid;
    logic [63:0] head_deadline;
    logic [8:0]  entry_count;
  } heap_result_t;

  // Behavioral heap plus the queue of results it predicts.
  class heap_scoreboard;
    logic [63:0]  slot_dl[Depth];
    logic [15:0]  slot_id[Depth];
    int           count;
    heap_result_t pending_q[$];
    int           errors;
    int           status_seen[4];

    function new();
      count  = 0;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic [63:0] d;
      logic [15:0] t;
      d = slot_dl[a]; t = slot_id[a];
      slot_dl[a] = slot_dl[b]; slot_id[a] = slot_id[b];
      slot_dl[b] = d; slot_id[b] = t;
    endfunction

    function int climb(int pos);
      int parent;
      while (pos != 0 && pos < count) begin
        parent = (pos - 1) / 2;
        if (!(slot_dl[pos] < slot_dl[parent])) break;
        swap_slots(pos, parent);
        pos = parent;
      end
      return pos;
    endfunction

    function void descend(int pos);
      int left, right, best;
      while (pos < count) begin
        left = pos * 2 + 1;
        right = left + 1;
        best = pos;
        if (left < count && slot_dl[left] < slot_dl[best]) best = left;
        if (right < count && slot_dl[right] < slot_dl[best]) best = right;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    endfunction

    // Apply one accepted operation and queue the result it must produce.
    function void note_op(logic [1:0] func, logic [63:0] dl, logic [63:0] now,
                          logic [15:0] id);
      heap_result_t r;
      r = '0;
      if (func == FuncSched) begin
        if (count >= Depth) r.status = StFull;
        else begin
          slot_dl[count] = dl;
          slot_id[count] = id;
          count++;
          void'(climb(count - 1));
        end
      end else if (func == FuncPop) begin
        if (count == 0 || slot_dl[0] > now) r.status = StNotDue;
        else begin
          r.task_id  = slot_id[0];
          r.deadline = slot_dl[0];
          count--;
          slot_dl[0] = slot_dl[count];
          slot_id[0] = slot_id[count];
          descend(0);
        end
      end else if (func == FuncCancel) begin
        r.status = StNotFound;
        for (int i = 0; i < count; i++) begin
          if (slot_id[i] == id) begin
            count--;
            slot_dl[i] = slot_dl[count];
            slot_id[i] = slot_id[count];
            if (i < count && climb(i) == i) descend(i);
            r.status = StOk;
            break;
          end
        end
      end
      r.head_valid    = (count != 0);
      r.head_deadline = (count != 0) ? slot_dl[0] : '0;
      r.entry_count   = count[8:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(heap_result_t act);
      heap_result_t exp;
      if (pending_q.size() == 0) begin
        $error("result with no pending expectation");
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      status_seen[act.status]++;
      if (act.status !== exp.status) begin
        $error("status: expected %0d actual %0d", exp.status, act.status); errors++;
      end
      if (act.task_id !== exp.task_id) begin
        $error("out_task_id: expected %0h actual %0h", exp.task_id, act.task_id); errors++;
      end
      if (act.deadline !== exp.deadline) begin
        $error("out_deadline: expected %0h actual %0h", exp.deadline, act.deadline);
        errors++;
      end
      if (act.head_valid !== exp.head_valid) begin
        $error("head_valid: expected %0b actual %0b", exp.head_valid, act.head_valid);
        errors++;
      end
      if (act.head_deadline !== exp.head_deadline) begin
        $error("head_deadline: expected %0h actual %0h",
               exp.head_deadline, act.head_deadline);
        errors++;
      end
      if (act.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d actual %0d", exp.entry_count, act.entry_count);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 5000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  func_i;
  logic [63:0] deadline_i, now_time_i;
  logic [15:0] task_id_i;
  logic        out_valid_o, out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] out_task_id_o;
  logic [63:0] out_deadline_o;
  logic        head_valid_o;
  logic [63:0] head_deadline_o;
  logic [8:0]  entry_count_o;

  heap_scoreboard sb;
  int ops_sent;
  logic [63:0] sim_clock;  // running notion of "now" for random traffic

  deadline_task_min_heap uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Drive one operation: idle for a random gap, then hold valid until the transfer.
  task automatic send_op(logic [1:0] func, logic [63:0] dl, logic [63:0] now,
                         logic [15:0] id);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i     = func;
    deadline_i = dl;
    now_time_i = now;
    task_id_i  = id;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_op(func, dl, now, id);
    ops_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] pick_deadline();
    case ($urandom_range(0, 9))
      0:       return {$urandom, $urandom};
      1:       return '1;
      2:       return '0;
      default: return sim_clock + $urandom_range(0, 400);
    endcase
  endfunction

  function automatic logic [15:0] pick_id();
    // Small pool makes duplicates and cancel hits common.
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
  endfunction

  task automatic random_op();
    int sel;
    sel = $urandom_range(0, 99);
    sim_clock += $urandom_range(0, 60);
    if (sel < 45)      send_op(FuncSched, pick_deadline(), {$urandom, $urandom}, pick_id());
    else if (sel < 80) send_op(FuncPop, {$urandom, $urandom},
                               ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : sim_clock,
                               16'($urandom));
    else if (sel < 95) send_op(FuncCancel, {$urandom, $urandom}, {$urandom, $urandom},
                               pick_id());
    else               send_op(2'd3, {$urandom, $urandom}, {$urandom, $urandom},
                               16'($urandom));
  endtask

  // Receiver: random stall per result, sample at the rising edge.
  initial begin
    int stall;
    heap_result_t act;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, 10);
      out_ready_i = (stall == 0);
      if (stall != 0) begin
        repeat (stall) @(negedge clk_i);
        out_ready_i = 1'b1;
      end
      do @(posedge clk_i); while (!out_valid_o);
      act = '{status_o, out_task_id_o, out_deadline_o, head_valid_o,
              head_deadline_o, entry_count_o};
      sb.check_result(act);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    ops_sent   = 0;
    sim_clock  = 64'd1000;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = FuncSched;
    deadline_i = '0;
    now_time_i = '0;
    task_id_i  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty pop/cancel, extremes, ties, duplicates, unused selector.
    send_op(FuncPop, '0, '1, '0);
    send_op(FuncCancel, '0, '0, 16'hffff);
    send_op(FuncSched, '1, '0, 16'hffff);
    send_op(FuncSched, '0, '1, 16'h0000);
    send_op(FuncSched, 64'd50, '0, 16'h0005);
    send_op(FuncSched, 64'd50, '0, 16'h0005);   // duplicate id, equal deadline
    send_op(FuncSched, 64'd50, '0, 16'h0006);
    send_op(FuncSched, 64'd20, '0, 16'h0007);
    send_op(2'd3, '1, '1, 16'hffff);
    send_op(FuncPop, '1, '0, '1);               // head deadline 0 due at now 0
    send_op(FuncPop, '0, 64'd19, '0);           // head 20 not yet due
    send_op(FuncPop, '0, 64'd20, '0);           // due exactly at deadline
    send_op(FuncCancel, '0, '0, 16'h0005);      // lowest-index duplicate goes
    send_op(FuncCancel, '0, '0, 16'h1234);
    send_op(FuncPop, '0, '1, '0);
    send_op(FuncPop, '0, '1, '0);
    send_op(FuncPop, '0, '1, '0);
    send_op(FuncPop, '0, '1, '0);

    // Fill to capacity, overflow, then drain.
    for (int i = 0; i < Depth + 3; i++)
      send_op(FuncSched, {$urandom, $urandom}, '0, 16'($urandom));
    send_op(FuncCancel, '0, '0, 16'($urandom));
    for (int i = 0; i < Depth + 2; i++) send_op(FuncPop, '0, '1, '0);

    for (int i = 0; i < 64; i++) begin
      if (i == 32) begin
        // Hold off the sender until every pending result has drained.
        in_valid_i = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk_i);
      end
      random_op();
    end
    in_valid_i = 1'b0;

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);

    $display("Sent %0d operations incl. fill to capacity, overflow and drain.", ops_sent);
    $display("Results by status: ok %0d, full %0d, not due %0d, not found %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
